### sv/pcbs_pkg.sv
package pcbs_pkg;

    localparam int INSP_W  = 7;
    localparam int TIME_W  = 16;
    localparam int PROD_W  = INSP_W + TIME_W;
    localparam int QUOT_W  = 15;
    localparam int PRES_W  = 16;
    localparam int FLOW_W  = 16;
    localparam int NOW_W   = 32;
    localparam int MODE_W  = 2;
    localparam int STAGE_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PS  = 2'd2;

    localparam logic [STAGE_W-1:0] STAGE_OFF    = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_INHALE = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_EXHALE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INSP_PRES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INSP_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_SENS = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic is_pressure_mode(input logic [MODE_W-1:0] m);
        return (m == MODE_PC) || (m == MODE_PS);
    endfunction

endpackage

### sv/pcbs_mul.sv
module pcbs_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcbs_pkg::INSP_W-1:0]   i_a,
    input  logic [pcbs_pkg::TIME_W-1:0]   i_b,
    output logic                          o_done,
    output logic [pcbs_pkg::PROD_W-1:0]   o_prod
);
    import pcbs_pkg::*;

    localparam int CNT_W = $clog2(INSP_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(INSP_W - 1);

    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [INSP_W-1:0] r_mplier;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // one multiplier bit per cycle, shift-add
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{INSP_W{1'b0}}, i_b};
            r_mplier <= i_a;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[INSP_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### sv/pcbs_div.sv
module pcbs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcbs_pkg::PROD_W-1:0]   i_num,
    input  logic [pcbs_pkg::TIME_W-1:0]   i_den,
    output logic                          o_done,
    output logic [pcbs_pkg::QUOT_W-1:0]   o_quot
);
    import pcbs_pkg::*;

    // dividend is i_num * 256; quotient known to fit QUOT_W bits
    localparam int DVD_W = PROD_W + 8;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

    logic [TIME_W-1:0] r_rem;
    logic [QUOT_W-1:0] r_dvd;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVD_W-1:0]  w_dvd_full;
    logic [TIME_W:0]   w_trial;
    logic              w_ge;

    assign w_dvd_full = {i_num, 8'h00};
    assign w_trial    = {r_rem, r_dvd[QUOT_W-1]};
    assign w_ge       = (w_trial >= {1'b0, i_den});

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_dvd_full[DVD_W-1:QUOT_W];
            r_dvd  <= w_dvd_full[QUOT_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= TIME_W'(w_trial - {1'b0, i_den});
            end else begin
                r_rem <= w_trial[TIME_W-1:0];
            end
            r_dvd  <= {r_dvd[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### sv/pressure_control_breath_sequencer.sv
// channel  | dir | fields (lsb first)
// s_axis   | in  | tdata: now_ms[31:0], mode[33:32], flow_average[49:34]
// m_axis   | out | tdata: stage[1:0], breath_done[2], desired_pressure[18:3],
//          |     |        patient_triggered[19]
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// A tick needing a ramp value runs a shift-add multiply, then a restoring
// divide, then the handoff and result load; other ticks go straight to the
// result load. One tick is in flight at a time.
// Synchronous active-low reset clears state and config to defaults.
// A finished result waits in the output register; a new tick may be
// accepted meanwhile, its result is held until the previous one is taken.
module pressure_control_breath_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // now_ms, mode, flow_average
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // stage, breath_done, desired_pressure,
                                        // patient_triggered
    input  logic                              i_cfg_we,
    input  logic [pcbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcbs_pkg::TIME_W-1:0]       i_cfg_data
);
    import pcbs_pkg::*;

    // config
    logic [INSP_W-1:0]        r_insp_pres;
    logic [INSP_W-1:0]        r_peep;
    logic [TIME_W-1:0]        r_rise;
    logic [TIME_W-1:0]        r_insp_time;
    logic [TIME_W-1:0]        r_max_exp;
    logic signed [FLOW_W-1:0] r_trig_sens;

    // sequencer state
    logic [MODE_W-1:0]  r_last_mode;
    logic [STAGE_W-1:0] r_stage;
    logic               r_completed;
    logic [NOW_W-1:0]   r_start;
    logic [PRES_W-1:0]  r_target;
    t_state             r_state, n_state;

    // result held until loaded to output
    logic [STAGE_W-1:0] r_res_stage;
    logic               r_res_done;
    logic               r_res_trig;

    logic               r_out_valid;
    logic [STAGE_W-1:0] r_out_stage;
    logic               r_out_done;
    logic [PRES_W-1:0]  r_out_pres;
    logic               r_out_trig;

    // input fields
    logic [NOW_W-1:0]         w_now;
    logic [MODE_W-1:0]        w_mode;
    logic signed [FLOW_W-1:0] w_flow;
    assign w_now  = s_axis_tdata[31:0];
    assign w_mode = s_axis_tdata[33:32];
    assign w_flow = s_axis_tdata[49:34];

    logic               w_accept;
    logic               w_entry;
    logic [STAGE_W-1:0] w_stage1;
    logic [NOW_W-1:0]   w_start1;
    logic [NOW_W-1:0]   w_elapsed;
    logic [STAGE_W-1:0] w_n_stage;
    logic [NOW_W-1:0]   w_n_start;
    logic               w_n_done;
    logic               w_trig;
    logic               w_ramp;
    logic               w_ramp_direct;
    logic               w_ramp_serial;
    logic [PRES_W-1:0]  w_top;
    logic [INSP_W:0]    w_top_sum;

    logic               w_mul_start;
    logic               w_mul_done;
    logic [PROD_W-1:0]  w_prod;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic               w_out_load;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_entry  = !is_pressure_mode(r_last_mode) && is_pressure_mode(w_mode);
    assign w_stage1 = w_entry ? STAGE_INHALE : r_stage;
    assign w_start1 = w_entry ? w_now : r_start;
    assign w_elapsed = w_now - w_start1;

    assign w_top_sum = {1'b0, r_peep} + {1'b0, r_insp_pres};
    assign w_top     = {w_top_sum, {(PRES_W - INSP_W - 1){1'b0}}};

    always_comb begin
        w_n_stage = w_stage1;
        w_n_start = w_start1;
        w_n_done  = r_completed;
        w_trig    = 1'b0;
        w_ramp    = 1'b0;
        if (w_mode == MODE_PC && w_stage1 == STAGE_INHALE) begin
            w_n_done = 1'b0;
            w_ramp   = 1'b1;
            if (w_elapsed >= {{(NOW_W - TIME_W){1'b0}}, r_insp_time}) begin
                w_n_stage = STAGE_EXHALE;
                w_n_start = w_now;
            end
        end else if (w_mode == MODE_PC && w_stage1 == STAGE_EXHALE) begin
            if (w_elapsed >= {{(NOW_W - TIME_W){1'b0}}, r_max_exp}) begin
                w_n_stage = STAGE_INHALE;
                w_n_done  = 1'b1;
                w_n_start = w_now;
            end else if (w_flow <= r_trig_sens) begin
                w_n_stage = STAGE_INHALE;
                w_n_done  = 1'b1;
                w_n_start = w_now;
                w_trig    = 1'b1;
            end
        end
    end

    // past the rise time the ramp is at or above the top: saturate
    assign w_ramp_direct = (r_rise == '0) ||
                           (w_elapsed >= {{(NOW_W - TIME_W){1'b0}}, r_rise});
    assign w_ramp_serial = w_ramp && !w_ramp_direct;

    pcbs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_insp_pres),
        .i_b     (w_elapsed[TIME_W-1:0]),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pcbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_rise),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_ramp_serial ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_mul_start   = (r_state == ST_IDLE) && s_axis_tvalid && w_ramp_serial;
        w_div_start   = (r_state == ST_MUL) && w_mul_done;
        w_out_load    = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_insp_pres <= '0;
            r_peep      <= '0;
            r_rise      <= TIME_W'(1);
            r_insp_time <= '0;
            r_max_exp   <= '0;
            r_trig_sens <= '0;
            r_last_mode <= MODE_OFF;
            r_stage     <= STAGE_OFF;
            r_completed <= 1'b1;
            r_start     <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INSP_PRES: r_insp_pres <= i_cfg_data[INSP_W-1:0];
                    CFG_PEEP:      r_peep      <= i_cfg_data[INSP_W-1:0];
                    CFG_RISE:      r_rise      <= i_cfg_data;
                    CFG_INSP_TIME: r_insp_time <= i_cfg_data;
                    CFG_MAX_EXP:   r_max_exp   <= i_cfg_data;
                    CFG_TRIG_SENS: r_trig_sens <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_last_mode <= w_mode;
                r_stage     <= w_n_stage;
                r_start     <= w_n_start;
                r_completed <= w_n_done;
                if (w_ramp && w_ramp_direct) begin
                    r_target <= w_top;
                end
            end else if (r_state == ST_DIV && w_div_done) begin
                r_target <= {1'b0, r_peep, 8'h00} + {1'b0, w_quot};
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_stage <= w_n_stage;
            r_res_done  <= w_n_done;
            r_res_trig  <= w_trig;
        end
        if (w_out_load) begin
            r_out_stage <= r_res_stage;
            r_out_done  <= r_res_done;
            r_out_pres  <= r_target;
            r_out_trig  <= r_res_trig;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out_trig, r_out_pres, r_out_done, r_out_stage};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("accepted a tick while one is in flight");

    a_trig_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_trig) |-> (r_out_stage == STAGE_INHALE && r_out_done))
        else $error("trigger result without new inhalation");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_div_done) |->
            ({1'b0, w_quot} <= {1'b0, r_insp_pres, 8'h00}))
        else $error("ramp increment past inspiratory pressure");

    a_div_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> $past(r_state == ST_MUL))
        else $error("divider started out of sequence");

    a_stage_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_stage != 2'd3))
        else $error("illegal stage on output");
`endif

endmodule

### test/tb_pressure_control_breath_sequencer.sv
`timescale 1ns / 1ps

module tb_pressure_control_breath_sequencer;
    import pcbs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int PHASES = 10;

    typedef struct packed {
        logic              trig;
        logic [PRES_W-1:0] pres;
        logic              done;
        logic [STAGE_W-1:0] stage;
    } t_breath_out;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_KNOWN
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [TIME_W-1:0]    val;
        logic [NOW_W-1:0]     now;
        logic [MODE_W-1:0]    mode;
        logic [FLOW_W-1:0]    flow;
        t_breath_out          out;
    } t_stim_row;

    typedef struct {
        logic [INSP_W-1:0] insp;
        logic [INSP_W-1:0] peep;
        logic [TIME_W-1:0] rise;
        logic [TIME_W-1:0] insp_time;
        logic [TIME_W-1:0] max_exp;
        logic [TIME_W-1:0] trig;
    } t_vent_cfg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;     // now_ms[31:0], mode[33:32], flow_average[49:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // stage[1:0], breath_done[2], desired_pressure[18:3],
                                        // patient_triggered[19]
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    // settings mirror
    logic [INSP_W-1:0]        set_insp = '0;
    logic [INSP_W-1:0]        set_peep = '0;
    logic [TIME_W-1:0]        set_rise = 16'd1;
    logic [TIME_W-1:0]        set_insp_time = '0;
    logic [TIME_W-1:0]        set_max_exp = '0;
    logic signed [TIME_W-1:0] set_trig = '0;

    // sequencer state mirror
    logic [MODE_W-1:0]  seq_last_mode = MODE_OFF;
    logic [STAGE_W-1:0] seq_stage = STAGE_OFF;
    logic               seq_done = 1'b1;
    logic [NOW_W-1:0]   seq_start = '0;
    logic [PRES_W-1:0]  seq_target = '0;

    t_breath_out expected_breaths[$];
    int mismatch_count = 0;
    int src_idle_pct = 25;
    int dst_idle_pct = 67;

    pressure_control_breath_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_breath_out advance_breath(input logic [NOW_W-1:0] now,
                                                   input logic [MODE_W-1:0] mode,
                                                   input logic signed [FLOW_W-1:0] flow);
        t_breath_out o;
        logic [63:0] top;
        logic [63:0] ramp;
        logic [63:0] since;
        logic [NOW_W-1:0] el32;
        logic trig;
        logic finish_exhale;
        trig = 1'b0;
        finish_exhale = 1'b0;
        if (!(seq_last_mode == MODE_PC || seq_last_mode == MODE_PS) &&
            (mode == MODE_PC || mode == MODE_PS)) begin
            seq_stage = STAGE_INHALE;
            seq_start = now;
        end
        seq_last_mode = mode;
        if (mode == MODE_PC) begin
            el32 = now - seq_start;
            if (seq_stage == STAGE_INHALE) begin
                seq_done = 1'b0;
                top = (64'(set_peep) + 64'(set_insp)) << 8;
                if (set_rise == '0) begin
                    ramp = top;
                end else begin
                    since = {32'd0, el32};
                    ramp = (64'(set_peep) << 8) + ((64'(set_insp) << 8) * since) / 64'(set_rise);
                    if (ramp > top)
                        ramp = top;
                end
                seq_target = ramp[PRES_W-1:0];
                if (el32 >= NOW_W'(set_insp_time)) begin
                    seq_stage = STAGE_EXHALE;
                    seq_start = now;
                end
            end else if (seq_stage == STAGE_EXHALE) begin
                if (el32 >= NOW_W'(set_max_exp)) begin
                    finish_exhale = 1'b1;
                end else if (flow <= set_trig) begin
                    finish_exhale = 1'b1;
                    trig = 1'b1;
                end
                if (finish_exhale) begin
                    seq_stage = STAGE_INHALE;
                    seq_done = 1'b1;
                    seq_start = now;
                end
            end
        end
        o.stage = seq_stage;
        o.done = seq_done;
        o.pres = seq_target;
        o.trig = trig;
        return o;
    endfunction

    function automatic t_stim_row row_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [TIME_W-1:0] val);
        t_stim_row r;
        r = '{kind: ROW_WRITE, idx: idx, val: val, now: '0, mode: MODE_OFF, flow: '0, out: '0};
        return r;
    endfunction

    function automatic t_stim_row row_tick(input logic [NOW_W-1:0] now,
                                           input logic [MODE_W-1:0] mode,
                                           input logic [FLOW_W-1:0] flow);
        t_stim_row r;
        r = '{kind: ROW_TICK, idx: '0, val: '0, now: now, mode: mode, flow: flow, out: '0};
        return r;
    endfunction

    function automatic t_stim_row row_known(input logic [NOW_W-1:0] now,
                                            input logic [MODE_W-1:0] mode,
                                            input logic [FLOW_W-1:0] flow,
                                            input logic [STAGE_W-1:0] stage,
                                            input logic done,
                                            input logic [PRES_W-1:0] pres,
                                            input logic trig);
        t_stim_row r;
        r = row_tick(now, mode, flow);
        r.kind = ROW_KNOWN;
        r.out = '{trig: trig, pres: pres, done: done, stage: stage};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_breaths.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_INSP_PRES: set_insp = val[INSP_W-1:0];
            CFG_PEEP:      set_peep = val[INSP_W-1:0];
            CFG_RISE:      set_rise = val;
            CFG_INSP_TIME: set_insp_time = val;
            CFG_MAX_EXP:   set_max_exp = val;
            CFG_TRIG_SENS: set_trig = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_vent_cfg c);
        wait_drained();
        cfg_write(CFG_INSP_PRES, TIME_W'(c.insp));
        cfg_write(CFG_PEEP, TIME_W'(c.peep));
        cfg_write(CFG_RISE, c.rise);
        cfg_write(CFG_INSP_TIME, c.insp_time);
        cfg_write(CFG_MAX_EXP, c.max_exp);
        cfg_write(CFG_TRIG_SENS, c.trig);
    endtask

    // leaves tvalid high after the transaction; the caller's next step lowers or reuses it
    task automatic send_tick(input logic [NOW_W-1:0] now, input logic [MODE_W-1:0] mode,
                             input logic [FLOW_W-1:0] flow, input logic known,
                             input t_breath_out known_out);
        t_breath_out predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, flow, mode, now};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_breath(now, mode, flow);
        expected_breaths.push_back(known ? known_out : predicted);
    endtask

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge i_clk) begin
        t_breath_out got;
        t_breath_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[19:0];
            if (expected_breaths.size() == 0) begin
                report_mismatch("unexpected transaction", int'(got), 0);
            end else begin
                want = expected_breaths.pop_front();
                if (got.stage !== want.stage)
                    report_mismatch("stage", int'(got.stage), int'(want.stage));
                if (got.done !== want.done)
                    report_mismatch("breath_done", int'(got.done), int'(want.done));
                if (got.pres !== want.pres)
                    report_mismatch("desired_pressure", int'(got.pres), int'(want.pres));
                if (got.trig !== want.trig)
                    report_mismatch("patient_triggered", int'(got.trig), int'(want.trig));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_pressure_control_breath_sequencer: done, errors");
        $finish;
    end

    initial begin
        t_stim_row dir_rows[$];
        t_vent_cfg c;
        logic [NOW_W-1:0] now_ms;
        logic [MODE_W-1:0] mode;
        logic [FLOW_W-1:0] flow;
        int r;
        int f;

        dir_rows = '{
            // reset settings: zero pressures, rise time of 1, zero inspiratory and expiratory times
            row_known(32'd0, MODE_OFF, 16'd0, STAGE_OFF, 1'b1, 16'd0, 1'b0),
            row_known(32'd5, MODE_PC, 16'd0, STAGE_EXHALE, 1'b0, 16'd0, 1'b0),
            row_known(32'd6, MODE_PC, 16'd100, STAGE_INHALE, 1'b1, 16'd0, 1'b0),
            row_known(32'd6, MODE_PC, 16'h8000, STAGE_EXHALE, 1'b0, 16'd0, 1'b0),
            row_known(32'd6, MODE_OTHER, 16'h7fff, STAGE_EXHALE, 1'b0, 16'd0, 1'b0),
            row_known(32'd7, MODE_PS, 16'd0, STAGE_INHALE, 1'b0, 16'd0, 1'b0),
            row_known(32'd8, MODE_OFF, 16'd0, STAGE_INHALE, 1'b0, 16'd0, 1'b0),
            row_write(CFG_INSP_PRES, 16'd127),
            row_write(CFG_PEEP, 16'd127),
            row_write(CFG_RISE, 16'd100),
            row_write(CFG_INSP_TIME, 16'd200),
            row_write(CFG_MAX_EXP, 16'hffff),
            row_write(CFG_TRIG_SENS, 16'h8000),
            // ramp starts at PEEP, saturates at PEEP + inspiratory
            row_known(32'd1000, MODE_PC, 16'd0, STAGE_INHALE, 1'b0, 16'd32512, 1'b0),
            row_tick(32'd1050, MODE_PC, 16'd0),
            row_known(32'd1200, MODE_PC, 16'd0, STAGE_EXHALE, 1'b0, 16'd65024, 1'b0),
            row_known(32'd1201, MODE_PC, 16'h8000, STAGE_INHALE, 1'b1, 16'd65024, 1'b1),
            row_tick(32'd1202, MODE_PC, 16'h7fff),
            row_tick(32'd1203, MODE_PS, 16'd0),
            row_tick(32'd1204, MODE_PC, 16'd0),
            row_tick(32'hffff_fff0, MODE_PC, 16'd0),
            row_tick(32'h0000_0010, MODE_PC, 16'h7fff),
            row_tick(32'h0001_0010, MODE_PC, 16'h7fff)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: begin
                    wait_drained();
                    cfg_write(dir_rows[i].idx, dir_rows[i].val);
                end
                ROW_TICK:  send_tick(dir_rows[i].now, dir_rows[i].mode, dir_rows[i].flow,
                                     1'b0, '0);
                default:   send_tick(dir_rows[i].now, dir_rows[i].mode, dir_rows[i].flow,
                                     1'b1, dir_rows[i].out);
            endcase
        end

        now_ms = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct = (ph < 4) ? 25 : (ph < 7) ? 67 : 0;
            dst_idle_pct = (ph < 4) ? 67 : (ph < 7) ? 25 : 0;
            if (ph == 0) begin
                c = '{insp: 7'd127, peep: 7'd127, rise: 16'hffff, insp_time: 16'hffff,
                      max_exp: 16'hffff, trig: 16'h7fff};
            end else if (ph == 1) begin
                c = '{insp: 7'd0, peep: 7'd0, rise: 16'd1, insp_time: 16'd0,
                      max_exp: 16'd0, trig: 16'h8000};
            end else begin
                c.insp = 7'($urandom_range(0, 127));
                c.peep = 7'($urandom_range(0, 127));
                c.rise = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
                c.insp_time = ($urandom_range(9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 50));
                c.max_exp = ($urandom_range(9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 80));
                c.trig = ($urandom_range(1) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(0, 200)) - 100);
                if (ph == 2)
                    c.rise = 16'd0;   // zero rise time jumps straight to the top
            end
            apply_settings(c);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 5 && n == 70)
                    wait_drained();
                r = $urandom_range(99);
                if (r < 3)
                    now_ms = $urandom;
                else if (r < 8)
                    now_ms = now_ms + $urandom_range(0, 70000);
                else
                    now_ms = now_ms + $urandom_range(0, 6);
                r = $urandom_range(99);
                mode = (r < 75) ? MODE_PC : (r < 85) ? MODE_PS : (r < 92) ? MODE_OFF : MODE_OTHER;
                if ($urandom_range(1) == 0) begin
                    flow = 16'($urandom);
                end else begin
                    f = int'(set_trig) + int'($urandom_range(0, 40)) - 20;
                    if (f > 32767)
                        f = 32767;
                    if (f < -32768)
                        f = -32768;
                    flow = f[FLOW_W-1:0];
                end
                send_tick(now_ms, mode, flow, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_pressure_control_breath_sequencer: done, clean");
        else
            $display("tb_pressure_control_breath_sequencer: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/pcbs_pkg.sv
sv/pcbs_mul.sv
sv/pcbs_div.sv
sv/pressure_control_breath_sequencer.sv
test/tb_pressure_control_breath_sequencer.sv
